>>> sv/i2c_master_bit_engine_assert.svh
// Assertion helpers for the RTL file that checks itself.
`ifndef I2C_MASTER_BIT_ENGINE_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define I2C_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds on a rising clock edge outside reset.
`define I2C_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> sv/i2c_mbe_pkg.sv
package i2c_mbe_pkg;

  // Request codes carried in req_type
  localparam logic [2:0] REQ_TICK  = 3'd0;
  localparam logic [2:0] REQ_START = 3'd1;
  localparam logic [2:0] REQ_STOP  = 3'd2;
  localparam logic [2:0] REQ_WRITE = 3'd3;
  localparam logic [2:0] REQ_READ  = 3'd4;

  // Bit phase count and last step of each command sequence
  localparam logic [4:0] BIT_PHASES      = 5'd16;
  localparam logic [4:0] LAST_STEP_START = 5'd2;
  localparam logic [4:0] LAST_STEP_STOP  = 5'd1;
  localparam logic [4:0] LAST_STEP_BYTE  = 5'd18;

  localparam logic [15:0] HALF_PERIOD_RESET = 16'd100;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] write_data;
    logic       send_ack;
    logic       sda_in;
  } req_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_received;
  } res_t;

endpackage

>>> sv/i2c_mbe_core.sv
module i2c_mbe_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  i2c_mbe_pkg::req_t   req_i,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i,
  output i2c_mbe_pkg::res_t   res_o
);
  import i2c_mbe_pkg::*;

  logic [15:0] half_q;
  cmd_e        cmd_q, cmd_d;
  logic [4:0]  step_q, step_d;
  logic [7:0]  shift_q, shift_d;
  logic [15:0] wait_q, wait_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;
  logic        sda_en_q, sda_en_d;
  logic        ack_bit_q, ack_bit_d;
  logic        ack_choice_q, ack_choice_d;
  logic [7:0]  last_read_q, last_read_d;
  logic        busy_q, busy_d;
  logic        done;

  // Sequence update for one transfer: tick countdown, phase end, phase entry
  always_comb begin
    logic        enter;
    logic [4:0]  enter_step;
    logic [4:0]  step_m1;
    logic [2:0]  bit_idx;
    logic [15:0] wait_dec;
    logic [15:0] load;
    logic [4:0]  last;
    logic [2:0]  cmd_code;

    cmd_d        = cmd_q;
    step_d       = step_q;
    shift_d      = shift_q;
    wait_d       = wait_q;
    scl_d        = scl_q;
    sda_d        = sda_q;
    sda_en_d     = sda_en_q;
    ack_bit_d    = ack_bit_q;
    ack_choice_d = ack_choice_q;
    last_read_d  = last_read_q;
    busy_d       = busy_q;
    done         = 1'b0;
    enter        = 1'b0;
    enter_step   = 5'd0;
    wait_dec     = wait_q;
    load         = (half_q == 16'd0) ? 16'd1 : half_q;
    cmd_code     = req_i.req_type - 3'd1;

    unique case (cmd_q)
      CMD_START: last = LAST_STEP_START;
      CMD_STOP:  last = LAST_STEP_STOP;
      default:   last = LAST_STEP_BYTE;
    endcase

    if (accept_i) begin
      if (req_i.req_type == REQ_TICK) begin
        if (busy_q) begin
          if (wait_q != 16'd0) begin
            wait_dec = wait_q - 16'd1;
          end
          wait_d = wait_dec;
          if (wait_dec == 16'd0) begin
            // Sample a read data bit at the end of its high phase
            if (cmd_q == CMD_READ && step_q >= 5'd1 && step_q <= BIT_PHASES && step_q[0]) begin
              shift_d = {shift_q[6:0], req_i.sda_in};
            end
            if (step_q >= last) begin
              if (cmd_q == CMD_WRITE) begin
                ack_bit_d = req_i.sda_in;
                scl_d     = 1'b0;
                sda_en_d  = 1'b1;
              end else if (cmd_q == CMD_READ) begin
                last_read_d = shift_d;
              end
              busy_d = 1'b0;
              step_d = 5'd0;
              wait_d = 16'd0;
              done   = 1'b1;
            end else begin
              enter      = 1'b1;
              enter_step = step_q + 5'd1;
            end
          end
        end
      end else if (req_i.req_type <= REQ_READ && !busy_q) begin
        cmd_d = cmd_e'(cmd_code[1:0]);
        if (cmd_d == CMD_WRITE) begin
          shift_d = req_i.write_data;
        end else if (cmd_d == CMD_READ) begin
          shift_d      = 8'd0;
          ack_choice_d = req_i.send_ack;
        end
        busy_d     = 1'b1;
        enter      = 1'b1;
        enter_step = 5'd0;
      end
    end

    // Drive the lines for the phase being entered and reload the wait
    step_m1 = enter_step - 5'd1;
    bit_idx = step_m1[3:1];
    if (enter) begin
      step_d = enter_step;
      wait_d = load;
      unique case (cmd_d)
        CMD_START: begin
          if (enter_step == 5'd0) begin
            scl_d = 1'b1;
            sda_d = 1'b1;
          end else if (enter_step == 5'd1) begin
            sda_d = 1'b0;
          end else begin
            scl_d = 1'b0;
          end
        end
        CMD_STOP: begin
          if (enter_step == 5'd0) begin
            sda_d = 1'b0;
            scl_d = 1'b1;
          end else begin
            sda_d = 1'b1;
          end
        end
        CMD_WRITE: begin
          if (enter_step == 5'd0) begin
            sda_en_d = 1'b1;
          end else if (enter_step <= BIT_PHASES) begin
            if (enter_step[0]) begin
              sda_d = shift_d[3'd7 - bit_idx];
              scl_d = 1'b1;
            end else begin
              scl_d = 1'b0;
            end
          end else if (enter_step == BIT_PHASES + 5'd1) begin
            sda_en_d = 1'b0;
          end else begin
            scl_d = 1'b1;
          end
        end
        default: begin
          if (enter_step == 5'd0) begin
            scl_d    = 1'b0;
            sda_en_d = 1'b0;
          end else if (enter_step <= BIT_PHASES) begin
            scl_d = enter_step[0];
          end else if (enter_step == BIT_PHASES + 5'd1) begin
            sda_en_d = 1'b1;
            sda_d    = ~ack_choice_d;
            scl_d    = 1'b1;
          end else begin
            scl_d = 1'b0;
          end
        end
      endcase
    end
  end

  // Hold the sequence state and the half period register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q       <= HALF_PERIOD_RESET;
      cmd_q        <= CMD_START;
      step_q       <= 5'd0;
      shift_q      <= 8'd0;
      wait_q       <= 16'd0;
      scl_q        <= 1'b1;
      sda_q        <= 1'b1;
      sda_en_q     <= 1'b1;
      ack_bit_q    <= 1'b0;
      ack_choice_q <= 1'b0;
      last_read_q  <= 8'd0;
      busy_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        half_q <= cfg_wdata_i;
      end
      cmd_q        <= cmd_d;
      step_q       <= step_d;
      shift_q      <= shift_d;
      wait_q       <= wait_d;
      scl_q        <= scl_d;
      sda_q        <= sda_d;
      sda_en_q     <= sda_en_d;
      ack_bit_q    <= ack_bit_d;
      ack_choice_q <= ack_choice_d;
      last_read_q  <= last_read_d;
      busy_q       <= busy_d;
    end
  end

  // Result of this transfer, taken by the output buffer
  always_comb begin
    res_o.scl_out      = scl_d;
    res_o.sda_out      = sda_d;
    res_o.sda_drive    = sda_en_d;
    res_o.busy_res     = busy_d;
    res_o.done_res     = done;
    res_o.read_data    = last_read_d;
    res_o.ack_received = ack_bit_d;
  end

endmodule

>>> sv/i2c_mbe_outbuf.sv
module i2c_mbe_outbuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  i2c_mbe_pkg::res_t data_i,
  output logic              full_o,
  output logic              valid_o,
  input  logic              stall_i,
  output i2c_mbe_pkg::res_t data_o
);
  import i2c_mbe_pkg::*;

  res_t       head_q;
  res_t       skid_q;
  logic [1:0] count_q;
  logic       pop;

  assign pop     = valid_o && !stall_i;
  assign valid_o = (count_q != 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign data_o  = head_q;

  // Track occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else if (push_i && !pop) begin
      count_q <= count_q + 2'd1;
    end else if (pop && !push_i) begin
      count_q <= count_q - 2'd1;
    end
  end

  // Advance the head and park a result in the skid slot
  always_ff @(posedge clk_i) begin
    if (push_i && !pop) begin
      if (count_q == 2'd0) begin
        head_q <= data_i;
      end else begin
        skid_q <= data_i;
      end
    end else if (pop && !push_i) begin
      head_q <= skid_q;
    end else if (pop && push_i) begin
      if (count_q == 2'd1) begin
        head_q <= data_i;
      end else begin
        head_q <= skid_q;
        skid_q <= data_i;
      end
    end
  end

endmodule

>>> sv/i2c_master_bit_engine.sv
// I2C master bit engine.
// Input channel: in_valid_i / in_stall_o carry one request per transfer: a
// tick (with the sampled SDA level) or a start, stop, write byte or read byte
// command. Output channel: out_valid_o / out_stall_i return exactly one result
// per request with the SCL/SDA drive levels, busy and done flags, the last
// read byte and the last write acknowledge.
// cfg_we_i / cfg_wdata_i load the half period in ticks; write it only while
// no request is outstanding.
// A result is registered in the output buffer and reaches the output behind
// any earlier results. Throughput: one request per cycle while in_stall_o is
// low; the sequence update is a single pass of logic into the state registers.
// A two-entry output buffer keeps input going while a result waits; once both
// entries are full under a stalled receiver, in_stall_o rises until one drains.
// Reset: no results pending, engine idle, SCL and SDA driven high, half
// period 100 ticks.
module i2c_master_bit_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  i2c_mbe_pkg::req_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output i2c_mbe_pkg::res_t out_data_o,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i
);
  import i2c_mbe_pkg::*;

  logic accept;
  res_t res;

  assign accept = in_valid_i && !in_stall_o;

  i2c_mbe_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .req_i       (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_o       (res)
  );

  i2c_mbe_outbuf u_outbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (res),
    .full_o  (in_stall_o),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_data_o)
  );

  `include "i2c_master_bit_engine_assert.svh"

  `I2C_ASSERT(a_stall_means_pending, in_stall_o |-> out_valid_o, "input stalled with no result pending")
  `I2C_ASSERT(a_done_ends_busy, (accept && res.done_res) |-> !res.busy_res, "done without leaving busy")
  `I2C_ASSERT(a_idle_drives_sda, (accept && !res.busy_res) |-> res.sda_drive, "SDA released while idle")
  `I2C_ASSERT_NEVER(a_busy_start, accept && res.done_res && in_data_i.req_type != REQ_TICK, "command finished a sequence")

endmodule
